### src/ppmd_pkg.sv
// Package for the PPM stream decoder: phase codes, result kinds, error codes,
// character constants, result, command and status types. No dependencies.
package ppmd_pkg;

	localparam logic [2:0] PH_MAGIC  = 3'd0;
	localparam logic [2:0] PH_WIDTH  = 3'd1;
	localparam logic [2:0] PH_HEIGHT = 3'd2;
	localparam logic [2:0] PH_MAXV   = 3'd3;
	localparam logic [2:0] PH_ASCII  = 3'd4;
	localparam logic [2:0] PH_BINARY = 3'd5;
	localparam logic [2:0] PH_DONE   = 3'd6;
	localparam logic [2:0] PH_FAIL   = 3'd7;

	localparam logic [1:0] KIND_HEADER = 2'd0;
	localparam logic [1:0] KIND_SAMPLE = 2'd1;
	localparam logic [1:0] KIND_ERROR  = 2'd2;

	localparam logic [2:0] ERR_MAGIC     = 3'd0;
	localparam logic [2:0] ERR_NUMBER    = 3'd1;
	localparam logic [2:0] ERR_MAX_BIG   = 3'd2;
	localparam logic [2:0] ERR_BUDGET    = 3'd3;
	localparam logic [2:0] ERR_SAMPLE    = 3'd4;
	localparam logic [2:0] ERR_TRUNCATED = 3'd5;

	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [15:0] MAGIC_P3 = 16'h5033;
	localparam logic [15:0] MAGIC_P6 = 16'h5036;

	localparam logic [34:0] INT_LIMIT    = 35'd2147483647;
	localparam logic [30:0] MAX_SAMPLE   = 31'd65535;
	localparam logic [24:0] BUDGET_RESET = 25'd22369621;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] raw;
		logic [1:0]  chan;
		logic [24:0] width;
		logic [24:0] height;
		logic [15:0] maxv;
		logic [2:0]  err;
		logic        last;
	} res_t;

	// controller to datapath
	typedef struct packed {
		logic       capture;
		logic       exec;
		logic       div_start;
		logic       load_out;
		logic       slot;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [1:0] res_count;
		logic       slot_sample;
		logic       div_done;
		logic       out_free;
	} stat_t;

endpackage

### src/ppmd_if.sv
// Stream and configuration interfaces of the PPM stream decoder.
// Depends on nothing but the widths given here.
interface ppmd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_file;
	modport source (output valid, in_byte, end_of_file, input ready);
	modport sink (input valid, in_byte, end_of_file, output ready);
endinterface

interface ppmd_out_if #(parameter int FRACTION_BITS = 16);
	logic                     valid;
	logic                     ready;
	logic [1:0]               result_kind;
	logic [FRACTION_BITS:0]   sample_value;
	logic [15:0]              raw_sample;
	logic [1:0]               channel_index;
	logic [24:0]              image_width;
	logic [24:0]              image_height;
	logic [15:0]              max_value;
	logic [2:0]               error_code;
	logic                     last_of_image;
	modport source (output valid, result_kind, sample_value, raw_sample, channel_index,
		image_width, image_height, max_value, error_code, last_of_image, input ready);
	modport sink (input valid, result_kind, sample_value, raw_sample, channel_index,
		image_width, image_height, max_value, error_code, last_of_image, output ready);
endinterface

interface ppmd_cfg_if;
	logic        valid;
	logic        ready;
	logic [24:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

### src/ppmd_div.sv
// Restoring divider for sample normalization, one quotient bit per cycle.
// Imports ppmd_pkg but uses nothing from it; parameter FRACTION_BITS.
module ppmd_div import ppmd_pkg::*; #(
	parameter int FRACTION_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [15:0]            raw,
	input  logic [15:0]            maxv,
	output logic                   done,
	output logic [FRACTION_BITS:0] quot
);
	localparam int NW = 17 + FRACTION_BITS;
	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] num_q;
	logic [15:0]   rem_q;
	logic [15:0]   div_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [16:0]   trial;
	logic          fits;

	assign trial = {rem_q, num_q[NW-1]};
	assign fits  = trial >= {1'b0, div_q};

	// load numerator (raw << F) + max/2, then shift one bit a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(NW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= ({1'b0, raw, FRACTION_BITS'(0)}) + NW'({1'b0, maxv[15:1]});
			rem_q <= '0;
			div_q <= maxv;
		end else if (busy_q) begin
			rem_q <= fits ? 16'(trial - {1'b0, div_q}) : trial[15:0];
			num_q <= {num_q[NW-2:0], fits};
		end
	end

	assign done = !busy_q && !start;
	assign quot = num_q[FRACTION_BITS:0];
endmodule

### src/ppmd_ctrl.sv
// Controller of the PPM stream decoder: accepts a byte, runs the parse step,
// then hands each result to the output register, samples via the divider.
// Depends on ppmd_pkg.
module ppmd_ctrl import ppmd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  stat_t stat,
	output cmd_t  cmd
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EXEC = 3'd1;
	localparam logic [2:0] S_SEL  = 3'd2;
	localparam logic [2:0] S_DIV  = 3'd3;
	localparam logic [2:0] S_PUT  = 3'd4;

	logic [2:0] state_q, state_d;
	logic [1:0] slot_q, slot_d;

	always_comb begin
		state_d       = state_q;
		slot_d        = slot_q;
		in_ready      = state_q == S_IDLE;
		cmd           = '0;
		cmd.slot      = slot_q[0];
		cmd.capture   = in_ready && in_valid;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_EXEC;
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				slot_d   = '0;
				state_d  = S_SEL;
			end
			S_SEL: begin
				if (slot_q >= stat.res_count) begin
					state_d = S_IDLE;
				end else if (stat.slot_sample) begin
					cmd.div_start = 1'b1;
					state_d       = S_DIV;
				end else begin
					state_d = S_PUT;
				end
			end
			S_DIV: begin
				if (stat.div_done) state_d = S_PUT;
			end
			S_PUT: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					slot_d       = slot_q + 1'b1;
					state_d      = S_SEL;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			slot_q  <= '0;
		end else begin
			state_q <= state_d;
			slot_q  <= slot_d;
		end
	end
endmodule

### src/ppmd_dp.sv
// Datapath of the PPM stream decoder: parse state, tokenizer and header checks,
// result buffer, divider and output register. Depends on ppmd_pkg, ppmd_div.
module ppmd_dp import ppmd_pkg::*; #(
	parameter int FRACTION_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cmd_t                   cmd,
	output stat_t                  stat,
	input  logic [7:0]             in_byte,
	input  logic                   in_eof,
	input  logic                   cfg_we,
	input  logic [24:0]            cfg_data,
	input  logic                   out_ready,
	output logic                   out_valid,
	output res_t                   out_res,
	output logic [FRACTION_BITS:0] out_val
);
	// parse state
	logic [2:0]  ph_q, n_ph;
	logic [30:0] acc_q, n_acc;
	logic [1:0]  cnt_q, n_cnt;
	logic [15:0] magic_q, n_magic;
	logic        minus_q, n_minus;
	logic        inc_q, n_inc;
	logic        pcr_q, n_pcr;
	logic [24:0] w_q, n_w;
	logic [24:0] h_q, n_h;
	logic [15:0] mx_q, n_mx;
	logic        bin_q, n_bin;
	logic [26:0] rem_q, n_rem;
	logic [7:0]  hb_q, n_hb;
	logic        bp_q, n_bp;
	logic [1:0]  ch_q, n_ch;
	logic [24:0] budget_q;
	logic [49:0] area_q;
	logic [7:0]  byte_q;
	logic        eof_q;

	// step scratch
	logic        skip, fin, gs_req, pv, tk_end;
	logic [15:0] gs_raw, bin_v;
	res_t        pres, f5res;
	logic        f5v;
	logic        has_digit;
	logic [30:0] tv;
	logic [34:0] nv;
	logic [3:0]  dig;
	logic        is_ws, is_dig;
	logic [15:0] smx, dmx_q;

	// result buffer and output register
	res_t        res0_q, res1_q, sel_res;
	logic [1:0]  rcount_q;
	logic        oval_q;
	res_t        ores_q;
	logic [FRACTION_BITS:0] oq_q, quot;
	logic        div_done;

	assign is_ws  = byte_q == CH_SPACE || (byte_q >= CH_TAB && byte_q <= CH_CR);
	assign is_dig = byte_q >= CH_ZERO && byte_q <= CH_NINE;
	assign dig    = 4'(byte_q - CH_ZERO);
	assign nv     = {acc_q, 3'b0} + {3'b0, acc_q, 1'b0} + {31'b0, dig};

	// one byte step of the parser
	always_comb begin
		n_ph = ph_q; n_acc = acc_q; n_cnt = cnt_q; n_magic = magic_q; n_minus = minus_q;
		n_inc = inc_q; n_pcr = pcr_q; n_w = w_q; n_h = h_q; n_mx = mx_q; n_bin = bin_q;
		n_rem = rem_q; n_hb = hb_q; n_bp = bp_q; n_ch = ch_q;
		skip = 1'b0; fin = 1'b0; gs_req = 1'b0; gs_raw = '0; pv = 1'b0; pres = '0;
		f5v = 1'b0; f5res = '0; has_digit = 1'b0; tv = '0; tk_end = 1'b0; bin_v = '0;
		if (ph_q < PH_DONE) begin
			if (pcr_q) begin
				n_pcr = 1'b0;
				if (byte_q == CH_LF) skip = 1'b1;
			end
			if (!skip) begin
				if (inc_q) begin
					if (byte_q == CH_LF) n_inc = 1'b0;
				end else if (ph_q == PH_BINARY) begin
					if (mx_q < 16'd256) begin
						bin_v = {8'b0, byte_q};
						tk_end = 1'b1;
					end else if (!bp_q) begin
						n_hb = byte_q;
						n_bp = 1'b1;
					end else begin
						n_bp = 1'b0;
						bin_v = {hb_q, byte_q};
						tk_end = 1'b1;
					end
					if (tk_end) begin
						if (bin_v > mx_q) begin
							n_ph = PH_FAIL; pv = 1'b1;
							pres.kind = KIND_ERROR; pres.err = ERR_SAMPLE;
						end else begin
							gs_req = 1'b1; gs_raw = bin_v;
						end
					end
				end else if (is_ws) begin
					if (cnt_q != 2'd0) begin
						if (byte_q == CH_CR) n_pcr = 1'b1;
						fin = 1'b1;
					end
				end else if (byte_q == CH_HASH) begin
					n_inc = 1'b1;
					if (cnt_q != 2'd0) fin = 1'b1;
				end else begin
					// token byte
					if (ph_q == PH_MAGIC) begin
						if (cnt_q == 2'd0) n_magic = {byte_q, 8'h00};
						else if (cnt_q == 2'd1) n_magic = {magic_q[15:8], byte_q};
					end else if (byte_q == CH_MINUS && cnt_q == 2'd0) begin
						n_minus = 1'b1;
					end else if (is_dig) begin
						if (ph_q == PH_ASCII) begin
							if (minus_q) begin
								if (dig != 4'd0) begin
									n_ph = PH_FAIL; pv = 1'b1;
									pres.kind = KIND_ERROR; pres.err = ERR_SAMPLE;
								end
							end else if (nv > {19'b0, mx_q}) begin
								n_ph = PH_FAIL; pv = 1'b1;
								pres.kind = KIND_ERROR; pres.err = ERR_SAMPLE;
							end else begin
								n_acc = nv[30:0];
							end
						end else if (!minus_q) begin
							if (nv > INT_LIMIT) begin
								n_ph = PH_FAIL; pv = 1'b1;
								pres.kind = KIND_ERROR; pres.err = ERR_NUMBER;
							end else begin
								n_acc = nv[30:0];
							end
						end
					end else begin
						n_ph = PH_FAIL; pv = 1'b1;
						pres.kind = KIND_ERROR;
						pres.err  = (ph_q == PH_ASCII) ? ERR_SAMPLE : ERR_NUMBER;
					end
					if (!pv && cnt_q != 2'd3) n_cnt = cnt_q + 1'b1;
				end
			end
		end
		// token end, also forced by the end-of-file byte
		if (eof_q && n_ph < PH_DONE && n_ph != PH_BINARY && n_cnt != 2'd0) fin = 1'b1;
		if (fin) begin
			has_digit = n_cnt > {1'b0, n_minus};
			tv = n_acc;
			if (n_ph == PH_MAGIC) begin
				if (n_cnt == 2'd2 && (n_magic == MAGIC_P3 || n_magic == MAGIC_P6)) begin
					n_bin = n_magic == MAGIC_P6;
					n_ph  = PH_WIDTH;
				end else begin
					n_ph = PH_FAIL; pv = 1'b1; pres.kind = KIND_ERROR; pres.err = ERR_MAGIC;
				end
			end else if (n_ph == PH_ASCII) begin
				if (!has_digit) begin
					n_ph = PH_FAIL; pv = 1'b1; pres.kind = KIND_ERROR; pres.err = ERR_SAMPLE;
				end else begin
					gs_req = 1'b1; gs_raw = tv[15:0];
				end
			end else if (!has_digit || n_minus || tv == '0) begin
				n_ph = PH_FAIL; pv = 1'b1; pres.kind = KIND_ERROR; pres.err = ERR_NUMBER;
			end else if (n_ph == PH_WIDTH) begin
				n_w  = (tv > {6'b0, budget_q}) ? '0 : tv[24:0];
				n_ph = PH_HEIGHT;
			end else if (n_ph == PH_HEIGHT) begin
				n_h  = (tv > {6'b0, budget_q}) ? '0 : tv[24:0];
				n_ph = PH_MAXV;
			end else if (tv > MAX_SAMPLE) begin
				n_ph = PH_FAIL; pv = 1'b1; pres.kind = KIND_ERROR; pres.err = ERR_MAX_BIG;
			end else if (w_q == '0 || h_q == '0 || area_q > {25'b0, budget_q}) begin
				n_ph = PH_FAIL; pv = 1'b1; pres.kind = KIND_ERROR; pres.err = ERR_BUDGET;
			end else begin
				n_mx  = tv[15:0];
				n_rem = 27'({area_q[26:0], 1'b0} + area_q[26:0]);
				n_ch  = '0; n_bp = 1'b0; n_hb = '0;
				pv = 1'b1;
				pres.kind = KIND_HEADER; pres.width = w_q; pres.height = h_q;
				pres.maxv = tv[15:0];
				n_ph = n_bin ? PH_BINARY : PH_ASCII;
			end
			n_cnt = '0; n_magic = '0; n_minus = 1'b0; n_acc = '0;
		end
		// hand out a sample
		if (gs_req && n_mx != '0 && n_rem != '0) begin
			n_rem = n_rem - 1'b1;
			pv = 1'b1;
			pres.kind = KIND_SAMPLE; pres.raw = gs_raw; pres.chan = n_ch;
			pres.last = n_rem == '0;
			n_ch = (n_ch >= 2'd2) ? 2'd0 : n_ch + 1'b1;
			if (n_rem == '0) n_ph = PH_DONE;
		end
		// keep the divisor of this step before the end of file clears it
		smx = n_mx;
		// end of file: report truncation if not done, then clear the parse state
		if (eof_q) begin
			if (n_ph < PH_DONE) begin
				f5v = 1'b1; f5res.kind = KIND_ERROR; f5res.err = ERR_TRUNCATED;
			end
			n_ph = PH_MAGIC; n_acc = '0; n_cnt = '0; n_magic = '0; n_minus = 1'b0;
			n_inc = 1'b0; n_pcr = 1'b0; n_w = '0; n_h = '0; n_mx = '0; n_bin = 1'b0;
			n_rem = '0; n_hb = '0; n_bp = 1'b0; n_ch = '0;
		end
	end

	// hold parse state, budget, result count and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_MAGIC; acc_q <= '0; cnt_q <= '0; magic_q <= '0; minus_q <= 1'b0;
			inc_q <= 1'b0; pcr_q <= 1'b0; w_q <= '0; h_q <= '0; mx_q <= '0; bin_q <= 1'b0;
			rem_q <= '0; hb_q <= '0; bp_q <= 1'b0; ch_q <= '0;
			budget_q <= BUDGET_RESET;
			rcount_q <= '0;
			oval_q   <= 1'b0;
		end else begin
			if (cfg_we) budget_q <= cfg_data;
			if (cmd.exec) begin
				ph_q <= n_ph; acc_q <= n_acc; cnt_q <= n_cnt; magic_q <= n_magic;
				minus_q <= n_minus; inc_q <= n_inc; pcr_q <= n_pcr; w_q <= n_w; h_q <= n_h;
				mx_q <= n_mx; bin_q <= n_bin; rem_q <= n_rem; hb_q <= n_hb; bp_q <= n_bp;
				ch_q <= n_ch;
				rcount_q <= 2'(pv) + 2'(f5v);
			end
			if (cmd.load_out) oval_q <= 1'b1;
			else if (out_ready) oval_q <= 1'b0;
		end
	end

	// capture the byte, area product, result slots and output payload
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			byte_q <= in_byte;
			eof_q  <= in_eof;
		end
		area_q <= w_q * h_q;
		if (cmd.exec) begin
			res0_q <= pv ? pres : f5res;
			res1_q <= f5res;
			dmx_q  <= smx;
		end
		if (cmd.load_out) begin
			ores_q <= sel_res;
			oq_q   <= (sel_res.kind == KIND_SAMPLE) ? quot : '0;
		end
	end

	assign sel_res = cmd.slot ? res1_q : res0_q;

	ppmd_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.raw   (sel_res.raw),
		.maxv  (dmx_q),
		.done  (div_done),
		.quot  (quot)
	);

	assign stat.res_count   = rcount_q;
	assign stat.slot_sample = sel_res.kind == KIND_SAMPLE;
	assign stat.div_done    = div_done;
	assign stat.out_free    = !oval_q || out_ready;

	assign out_valid = oval_q;
	assign out_res   = ores_q;
	assign out_val   = oq_q;
endmodule

### src/ppm_stream_decoder.sv
// Top level of the PPM P3/P6 stream decoder: joins ppmd_ctrl and ppmd_dp to
// the stream and configuration interfaces. Depends on ppmd_pkg, ppmd_if.
//
//   channel      dir  request moves
//   in_stream    in   one file byte and its end-of-file mark
//   out_stream   out  one header, sample or error result
//   cfg          in   new pixel budget (always ready)
//
// A byte is accepted, takes its parse step and has its results dispatched; a
// header or error result goes straight to the output register, and a sample
// first passes the normalizing divider, which gives one quotient bit a cycle.
// A full output register holds dispatch until its result is taken.
// The output register lets the next byte in while a result waits to be taken.
// Reset clears the parse state and loads the default pixel budget.
module ppm_stream_decoder import ppmd_pkg::*; #(
	parameter int FRACTION_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	ppmd_in_if.sink    in_stream,
	ppmd_out_if.source out_stream,
	ppmd_cfg_if.sink   cfg
);
	cmd_t  cmd;
	stat_t stat;
	res_t  ores;

	assign cfg.ready = 1'b1;

	ppmd_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_stream.valid),
		.in_ready(in_stream.ready),
		.stat    (stat),
		.cmd     (cmd)
	);

	ppmd_dp #(.FRACTION_BITS(FRACTION_BITS)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.in_byte  (in_stream.in_byte),
		.in_eof   (in_stream.end_of_file),
		.cfg_we   (cfg.valid),
		.cfg_data (cfg.data),
		.out_ready(out_stream.ready),
		.out_valid(out_stream.valid),
		.out_res  (ores),
		.out_val  (out_stream.sample_value)
	);

	assign out_stream.result_kind   = ores.kind;
	assign out_stream.raw_sample    = ores.raw;
	assign out_stream.channel_index = ores.chan;
	assign out_stream.image_width   = ores.width;
	assign out_stream.image_height  = ores.height;
	assign out_stream.max_value     = ores.maxv;
	assign out_stream.error_code    = ores.err;
	assign out_stream.last_of_image = ores.last;
endmodule
